// ===== sv/dpp_pkg.sv =====
// ---------------------------------------------------------------------------
// dpp_pkg: shared types and constants
// Configuration layout, queue entry format and sizing for the depth pixel
// back-projection core.
// ---------------------------------------------------------------------------
package dpp_pkg;

   localparam int unsigned MAX_DIM    = 4096;
   localparam int unsigned DIM_W      = 13;   // holds 1..MAX_DIM
   localparam int unsigned POS_W      = 12;   // holds 0..MAX_DIM-1
   localparam int unsigned DEC_MAX    = 16;
   localparam int unsigned PHASE_W    = 4;
   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = 2;
   localparam int unsigned ROUND_SH   = 28;

   typedef enum logic [2:0] {
      CSR_IMAGE_WIDTH    = 3'd0,
      CSR_IMAGE_HEIGHT   = 3'd1,
      CSR_DECIMATE       = 3'd2,
      CSR_CENTER_X_Q4    = 3'd3,
      CSR_CENTER_Y_Q4    = 3'd4,
      CSR_INV_FOCAL_Q24  = 3'd5,
      CSR_RANGE_LIMIT_MM = 3'd6,
      CSR_RANGE_ENABLE   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic [4:0]  decimate;
      logic [15:0] center_x_q4;
      logic [15:0] center_y_q4;
      logic [23:0] inv_focal_q24;
      logic [15:0] range_limit_mm;
      logic        range_enable;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
      logic [15:0]      depth_mm;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
   } item_type;

endpackage

// ===== sv/dpp_intf.sv =====
// ---------------------------------------------------------------------------
// dpp_req_if / dpp_rsp_if: pixel and point channels
// Valid/ready channels carrying one depth pixel or one projected point.
// ---------------------------------------------------------------------------
interface dpp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] depth_mm;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;

   modport source (output valid, depth_mm, red, green, blue, input ready);
   modport sink   (input valid, depth_mm, red, green, blue, output ready);
endinterface

interface dpp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_mm;
   logic signed [31:0] y_mm;
   logic [15:0]        z_mm;
   logic [7:0]         out_red;
   logic [7:0]         out_green;
   logic [7:0]         out_blue;

   modport source (output valid, x_mm, y_mm, z_mm, out_red, out_green, out_blue,
                   input ready);
   modport sink   (input valid, x_mm, y_mm, z_mm, out_red, out_green, out_blue,
                   output ready);
endinterface

// ===== sv/dpp_front.sv =====
// ---------------------------------------------------------------------------
// dpp_front: raster tracking and pixel selection
// Tracks column/row and decimation phases, keeps on-grid in-range pixels.
// ---------------------------------------------------------------------------
module dpp_front (
   input  logic               clock,
   input  logic               reset,
   input  dpp_pkg::cfg_type   cfg,
   dpp_req_if.sink            req,
   output logic               push_valid,
   input  logic               push_ready,
   output dpp_pkg::item_type  push_item
);

   logic [dpp_pkg::POS_W-1:0]   column_ff, column_in;
   logic [dpp_pkg::POS_W-1:0]   row_ff, row_in;
   logic [dpp_pkg::PHASE_W-1:0] column_phase_ff, column_phase_in;
   logic [dpp_pkg::PHASE_W-1:0] row_phase_ff, row_phase_in;

   logic [dpp_pkg::DIM_W-1:0]   width_lim, height_lim;
   logic [4:0]                  dec_lim;
   logic [dpp_pkg::DIM_W-1:0]   column_inc, row_inc;
   logic [4:0]                  column_phase_inc, row_phase_inc;
   logic                        keep;
   logic                        accept;

   // clamp sizes and decimation into their legal ranges
   always_comb begin
      if (cfg.image_width == '0) begin
         width_lim = dpp_pkg::DIM_W'(1);
      end else if (cfg.image_width > dpp_pkg::DIM_W'(dpp_pkg::MAX_DIM)) begin
         width_lim = dpp_pkg::DIM_W'(dpp_pkg::MAX_DIM);
      end else begin
         width_lim = cfg.image_width;
      end
      if (cfg.image_height == '0) begin
         height_lim = dpp_pkg::DIM_W'(1);
      end else if (cfg.image_height > dpp_pkg::DIM_W'(dpp_pkg::MAX_DIM)) begin
         height_lim = dpp_pkg::DIM_W'(dpp_pkg::MAX_DIM);
      end else begin
         height_lim = cfg.image_height;
      end
      if (cfg.decimate == '0) begin
         dec_lim = 5'd1;
      end else if (cfg.decimate > 5'(dpp_pkg::DEC_MAX)) begin
         dec_lim = 5'(dpp_pkg::DEC_MAX);
      end else begin
         dec_lim = cfg.decimate;
      end
   end

   always_comb begin
      keep = (column_phase_ff == '0) && (row_phase_ff == '0) &&
             !(cfg.range_enable && (req.depth_mm > cfg.range_limit_mm));
      req.ready  = push_ready;
      accept     = req.valid && push_ready;
      push_valid = req.valid && keep;
      push_item.column   = column_ff;
      push_item.row      = row_ff;
      push_item.depth_mm = req.depth_mm;
      push_item.red      = req.red;
      push_item.green    = req.green;
      push_item.blue     = req.blue;
   end

   // advance raster position, wrapping at the end of a row and of a frame
   always_comb begin
      column_inc       = {1'b0, column_ff} + dpp_pkg::DIM_W'(1);
      row_inc          = {1'b0, row_ff} + dpp_pkg::DIM_W'(1);
      column_phase_inc = {1'b0, column_phase_ff} + 5'd1;
      row_phase_inc    = {1'b0, row_phase_ff} + 5'd1;
      column_in        = column_ff;
      row_in           = row_ff;
      column_phase_in  = column_phase_ff;
      row_phase_in     = row_phase_ff;
      if (accept) begin
         if (column_inc >= width_lim) begin
            column_in       = '0;
            column_phase_in = '0;
            if (row_inc >= height_lim) begin
               row_in       = '0;
               row_phase_in = '0;
            end else begin
               row_in       = row_inc[dpp_pkg::POS_W-1:0];
               row_phase_in = (row_phase_inc >= dec_lim) ? '0 :
                              row_phase_inc[dpp_pkg::PHASE_W-1:0];
            end
         end else begin
            column_in       = column_inc[dpp_pkg::POS_W-1:0];
            column_phase_in = (column_phase_inc >= dec_lim) ? '0 :
                              column_phase_inc[dpp_pkg::PHASE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff       <= '0;
         row_ff          <= '0;
         column_phase_ff <= '0;
         row_phase_ff    <= '0;
      end else begin
         column_ff       <= column_in;
         row_ff          <= row_in;
         column_phase_ff <= column_phase_in;
         row_phase_ff    <= row_phase_in;
      end
   end

endmodule

// ===== sv/dpp_fifo.sv =====
// ---------------------------------------------------------------------------
// dpp_fifo: short queue between selection and projection
// Holds kept pixels so front and back stall independently.
// ---------------------------------------------------------------------------
module dpp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  dpp_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output dpp_pkg::item_type pop_item
);

   dpp_pkg::item_type             entry_ff [dpp_pkg::FIFO_DEPTH];
   logic [dpp_pkg::FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [dpp_pkg::FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [dpp_pkg::FIFO_AW:0]     count_ff, count_in;
   logic                          push, pop;

   always_comb begin
      push_ready = (count_ff != (dpp_pkg::FIFO_AW+1)'(dpp_pkg::FIFO_DEPTH));
      pop_valid  = (count_ff != '0);
      pop_item   = entry_ff[rd_ptr_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + (dpp_pkg::FIFO_AW+1)'(push) - (dpp_pkg::FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/dpp_back.sv =====
// ---------------------------------------------------------------------------
// dpp_back: pinhole projection pipeline
// Three stages: depth times offset, times focal reciprocal, round and sign.
// ---------------------------------------------------------------------------
module dpp_back (
   input  logic              clock,
   input  logic              reset,
   input  dpp_pkg::cfg_type  cfg,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  dpp_pkg::item_type pop_item,
   dpp_rsp_if.source         rsp
);

   localparam int unsigned PROD_W = 56;
   localparam int unsigned Q_W    = PROD_W + 1 - dpp_pkg::ROUND_SH;

   logic                 advance;
   logic signed [16:0]   dx, dy;
   logic [15:0]          mag_x, mag_y;

   // stage 1
   logic                 s1_valid_ff;
   logic [31:0]          s1_px_ff, s1_py_ff;
   logic                 s1_nx_ff, s1_ny_ff;
   dpp_pkg::item_type    s1_item_ff;
   // stage 2
   logic                 s2_valid_ff;
   logic [PROD_W-1:0]    s2_px_ff, s2_py_ff;
   logic                 s2_nx_ff, s2_ny_ff;
   dpp_pkg::item_type    s2_item_ff;
   // stage 3 (output register)
   logic                 s3_valid_ff;
   logic signed [31:0]   s3_x_ff, s3_x_in, s3_y_ff, s3_y_in;
   dpp_pkg::item_type    s3_item_ff;

   logic [PROD_W:0]      sum_x, sum_y;
   logic [Q_W-1:0]       q_x, q_y;

   always_comb begin
      advance   = !s3_valid_ff || rsp.ready;
      pop_ready = advance;
      dx    = $signed({1'b0, pop_item.column, 4'b0000}) - $signed({1'b0, cfg.center_x_q4});
      dy    = $signed({1'b0, pop_item.row, 4'b0000}) - $signed({1'b0, cfg.center_y_q4});
      mag_x = dx[16] ? 16'(-dx) : dx[15:0];
      mag_y = dy[16] ? 16'(-dy) : dy[15:0];
   end

   // round half away from zero on the magnitude, then apply sign
   always_comb begin
      sum_y   = {1'b0, s2_py_ff} + ((PROD_W+1)'(1) << (dpp_pkg::ROUND_SH - 1));
      sum_x   = {1'b0, s2_px_ff} + ((PROD_W+1)'(1) << (dpp_pkg::ROUND_SH - 1));
      q_x     = sum_x[PROD_W:dpp_pkg::ROUND_SH];
      q_y     = sum_y[PROD_W:dpp_pkg::ROUND_SH];
      s3_x_in = s2_nx_ff ? -$signed(32'(q_x)) : $signed(32'(q_x));
      s3_y_in = s2_ny_ff ? -$signed(32'(q_y)) : $signed(32'(q_y));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= pop_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_px_ff   <= mag_x * pop_item.depth_mm;
         s1_py_ff   <= mag_y * pop_item.depth_mm;
         s1_nx_ff   <= dx[16];
         s1_ny_ff   <= dy[16];
         s1_item_ff <= pop_item;
         s2_px_ff   <= PROD_W'(s1_px_ff) * PROD_W'(cfg.inv_focal_q24);
         s2_py_ff   <= PROD_W'(s1_py_ff) * PROD_W'(cfg.inv_focal_q24);
         s2_nx_ff   <= s1_nx_ff;
         s2_ny_ff   <= s1_ny_ff;
         s2_item_ff <= s1_item_ff;
         s3_x_ff    <= s3_x_in;
         s3_y_ff    <= s3_y_in;
         s3_item_ff <= s2_item_ff;
      end
   end

   always_comb begin
      rsp.valid     = s3_valid_ff;
      rsp.x_mm      = s3_x_ff;
      rsp.y_mm      = s3_y_ff;
      rsp.z_mm      = s3_item_ff.depth_mm;
      rsp.out_red   = s3_item_ff.red;
      rsp.out_green = s3_item_ff.green;
      rsp.out_blue  = s3_item_ff.blue;
   end

endmodule

// ===== sv/depth_pixel_to_point_core.sv =====
// ---------------------------------------------------------------------------
// depth_pixel_to_point_core: depth image back-projection to colored points
// A kept pixel passes through the queue and the s1, s2, s3 registers to rsp.
// Throughput: one pixel per clock while the queue has room; the projection pipeline
// stalls as one unit on rsp backpressure and a four-entry queue absorbs the front side.
// Reset (synchronous, active high) clears raster counters, queue and pipeline
// valids and loads the register defaults 640/480/2/5120/3840/33554/5000/1.
// ---------------------------------------------------------------------------
module depth_pixel_to_point_core (
   input  logic                               clock,
   input  logic                               reset,
   dpp_req_if.sink                            req,
   dpp_rsp_if.source                          rsp,
   input  logic                               csr_write_enable,
   input  logic [2:0]                         csr_index,
   input  logic [dpp_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   dpp_pkg::cfg_type  cfg_ff, cfg_in;
   logic              push_valid, push_ready;
   dpp_pkg::item_type push_item;
   logic              pop_valid, pop_ready;
   dpp_pkg::item_type pop_item;

   // decode register writes; each register keeps only its own width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (dpp_pkg::csr_index_type'(csr_index))
            dpp_pkg::CSR_IMAGE_WIDTH:    cfg_in.image_width    = csr_write_data[12:0];
            dpp_pkg::CSR_IMAGE_HEIGHT:   cfg_in.image_height   = csr_write_data[12:0];
            dpp_pkg::CSR_DECIMATE:       cfg_in.decimate       = csr_write_data[4:0];
            dpp_pkg::CSR_CENTER_X_Q4:    cfg_in.center_x_q4    = csr_write_data[15:0];
            dpp_pkg::CSR_CENTER_Y_Q4:    cfg_in.center_y_q4    = csr_write_data[15:0];
            dpp_pkg::CSR_INV_FOCAL_Q24:  cfg_in.inv_focal_q24  = csr_write_data[23:0];
            dpp_pkg::CSR_RANGE_LIMIT_MM: cfg_in.range_limit_mm = csr_write_data[15:0];
            dpp_pkg::CSR_RANGE_ENABLE:   cfg_in.range_enable   = csr_write_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // hold configuration; load defaults on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width    <= 13'd640;
         cfg_ff.image_height   <= 13'd480;
         cfg_ff.decimate       <= 5'd2;
         cfg_ff.center_x_q4    <= 16'd5120;
         cfg_ff.center_y_q4    <= 16'd3840;
         cfg_ff.inv_focal_q24  <= 24'd33554;
         cfg_ff.range_limit_mm <= 16'd5000;
         cfg_ff.range_enable   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: track raster position, drop off-grid and out-of-range pixels
   dpp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // queue: decouple selection from projection
   dpp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // back: project through the pinhole model and drive the point channel
   dpp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp       (rsp)
   );

endmodule
